[sv/sns_pkg.sv]
// sns_pkg: shared constants, types and round functions for the nonce scan unit
// no dependencies
package sns_pkg;

  localparam int unsigned ChunkBitsDefault = 12;
  localparam int unsigned NumHdrWords      = 8;
  localparam int unsigned CfgIdxW          = 3;

  localparam logic [CfgIdxW-1:0] CFG_HDR0 = 3'd0;

  // datapath commands
  typedef struct packed {
    logic load_mid;    // load iv, message = header block
    logic load_first;  // load midstate, message = tail block with nonce
    logic load_second; // load iv, message = first hash block
    logic round;       // one compression round
    logic finish;      // add working vars into chaining value
    logic save_mid;    // keep result as midstate
    logic nonce_load;  // nonce <= start + 1
    logic nonce_inc;   // nonce <= nonce + 1
  } sns_cmd_t;

  typedef struct packed {
    logic last_round;
    logic hit;
    logic chunk_end;
  } sns_sts_t;

  localparam logic [255:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] k_const(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

[sv/sns_ctrl.sv]
// sns_ctrl: sequencer for midstate, first and second compressions of each nonce
// depends on sns_pkg
module sns_ctrl
  import sns_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_fire,
  input  sns_sts_t sts,
  output sns_cmd_t cmd,
  output logic     in_ready,
  output logic     out_valid
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MID  = 3'd1;
  localparam logic [2:0] S_H1   = 3'd2;
  localparam logic [2:0] S_H2   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_mid = 1'b1;
          cmd.nonce_load = 1'b1;
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        cmd.round = 1'b1;
        if (sts.last_round) begin
          cmd.save_mid = 1'b1;
          cmd.load_first = 1'b1;
          state_nxt = S_H1;
        end
      end
      S_H1: begin
        cmd.round = 1'b1;
        if (sts.last_round) begin
          cmd.finish = 1'b1;
          cmd.load_second = 1'b1;
          state_nxt = S_H2;
        end
      end
      S_H2: begin
        cmd.round = 1'b1;
        if (sts.last_round) begin
          cmd.finish = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.hit && !sts.chunk_end) begin
          cmd.nonce_inc = 1'b1;
          cmd.load_first = 1'b1;
          state_nxt = S_H1;
        end else if (out_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE) && (sts.hit || sts.chunk_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_done_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> state_r == S_IDLE) else $error("no return to idle");
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_mid, cmd.load_first, cmd.load_second}))
    else $error("two loads");
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_MID) else $error("accept lost");

endmodule

[sv/sns_dp.sv]
// sns_dp: sha-256 round datapath, one round per cycle, with message schedule
// depends on sns_pkg
module sns_dp
  import sns_pkg::*;
#(
  parameter int unsigned CHUNK_BITS = ChunkBitsDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sns_cmd_t       cmd,
  input  logic [511:0]   hdr,
  input  logic [31:0]    root_tail,
  input  logic [31:0]    time_field,
  input  logic [31:0]    target_bits,
  input  logic [31:0]    start_nonce,
  output sns_sts_t       sts,
  output logic [31:0]    nonce,
  output logic [255:0]   hash
);

  logic [31:0]  tail_r [3];
  logic [31:0]  nonce_r;
  logic [255:0] mid_r, h_r, hin_r;
  logic [31:0]  w_r [16];
  logic [31:0]  v_r [8];
  // counts the 64 rounds; the sum is taken when it reaches 64
  logic [6:0]   rnd_r;

  logic [31:0] msg [16];
  logic [31:0] init [8];
  logic [255:0] init_v;
  logic [31:0] s0, s1, wn, t1, t2, ch, mj, e1, a1;
  logic        any_load;
  logic [255:0] sum;

  assign any_load = cmd.load_mid | cmd.load_first | cmd.load_second;

  always_comb begin
    for (int i = 0; i < 16; i++) msg[i] = '0;
    init_v = IV;
    if (cmd.load_mid) begin
      for (int i = 0; i < 16; i++) msg[i] = swap32(hdr[32*i +: 32]);
    end else if (cmd.load_first) begin
      init_v = cmd.save_mid ? sum : mid_r;
      msg[0] = swap32(tail_r[0]);
      msg[1] = swap32(tail_r[1]);
      msg[2] = swap32(tail_r[2]);
      msg[3] = swap32(cmd.nonce_inc ? nonce_r + 32'd1 : nonce_r);
      msg[4] = 32'h80000000;
      msg[15] = 32'd640;
    end else begin
      for (int i = 0; i < 8; i++) msg[i] = sum[255-32*i -: 32];
      msg[8] = 32'h80000000;
      msg[15] = 32'd256;
    end
    for (int i = 0; i < 8; i++) init[i] = init_v[255-32*i -: 32];
  end

  // chaining value plus working vars
  always_comb begin
    for (int i = 0; i < 8; i++) sum[255-32*i -: 32] = hin_r[255-32*i -: 32] + v_r[i];
  end

  assign s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wn = w_r[0] + s0 + w_r[9] + s1;
  assign e1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign a1 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1 = v_r[7] + e1 + ch + k_const(rnd_r[5:0]) + w_r[0];
  assign t2 = a1 + mj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
    end else if (any_load) begin
      rnd_r <= '0;
    end else if (cmd.round) begin
      rnd_r <= rnd_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mid) begin
      tail_r[0] <= root_tail;
      tail_r[1] <= time_field;
      tail_r[2] <= target_bits;
    end
    if (cmd.nonce_load) nonce_r <= start_nonce + 32'd1;
    else if (cmd.nonce_inc) nonce_r <= nonce_r + 32'd1;
    if (cmd.save_mid) mid_r <= sum;
    if (cmd.finish) h_r <= sum;
    if (any_load) begin
      hin_r <= init_v;
      for (int i = 0; i < 16; i++) w_r[i] <= msg[i];
      for (int i = 0; i < 8; i++) v_r[i] <= init[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      v_r[0] <= t1 + t2;
      for (int i = 1; i < 8; i++) begin
        if (i != 4) v_r[i] <= v_r[i-1];
      end
      v_r[4] <= v_r[3] + t1;
    end
  end

  assign sts.last_round = (rnd_r == 7'd64);
  assign sts.hit        = (h_r[15:0] == 16'd0);
  assign sts.chunk_end  = (nonce_r[CHUNK_BITS-1:0] == '0);
  assign nonce = nonce_r;
  assign hash  = h_r;

endmodule

[sv/sha256d_nonce_scan_unit.sv]
// sha256d_nonce_scan_unit: top level of the double sha-256 nonce scan
// depends on sns_pkg, sns_ctrl, sns_dp
//
// One transaction in gives one transaction out. The header's first 64 bytes
// come from the eight configuration words and are compressed once per
// transaction (midstate). Each nonce then costs two 64-round compressions
// on a single shared round unit, one round per cycle, after which the
// digest is tested. A scan covers 1 to 2^SCAN_CHUNK_BITS nonces, up to
// 4096 nonces at the default chunk. The result holds in the output
// register until taken; a new transaction is accepted once it is gone.
module sha256d_nonce_scan_unit
  import sns_pkg::*;
#(
  parameter int unsigned SCAN_CHUNK_BITS = ChunkBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_root_tail,
  input  logic [31:0]        in_time_field,
  input  logic [31:0]        in_target_bits,
  input  logic [31:0]        in_start_nonce,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [31:0]        out_final_nonce,
  output logic [63:0]        out_digest_0,
  output logic [63:0]        out_digest_1,
  output logic [63:0]        out_digest_2,
  output logic [63:0]        out_digest_3
);

  logic [63:0]  hdr_r [NumHdrWords];
  logic [511:0] hdr;
  sns_cmd_t     cmd;
  sns_sts_t     sts;
  logic [255:0] hash;
  logic [31:0]  nonce;
  logic         in_fire, out_fire;

  // header words, little-endian packed bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumHdrWords; i++) hdr_r[i] <= '0;
    end else if (cfg_we) begin
      hdr_r[cfg_index - CFG_HDR0] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < NumHdrWords; i++) hdr[64*i +: 64] = hdr_r[i];
  end

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  sns_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts, .cmd, .in_ready, .out_valid
  );

  sns_dp #(.CHUNK_BITS(SCAN_CHUNK_BITS)) u_dp (
    .clk, .rst_n, .cmd, .hdr,
    .root_tail(in_root_tail), .time_field(in_time_field),
    .target_bits(in_target_bits), .start_nonce(in_start_nonce),
    .sts, .nonce, .hash
  );

  // hash word 0 sits in the top bits; output bytes follow sha-256 order
  assign out_found       = sts.hit;
  assign out_final_nonce = nonce;
  assign out_digest_0 = {swap32(hash[223:192]), swap32(hash[255:224])};
  assign out_digest_1 = {swap32(hash[159:128]), swap32(hash[191:160])};
  assign out_digest_2 = {swap32(hash[95:64]),   swap32(hash[127:96])};
  assign out_digest_3 = {swap32(hash[31:0]),    swap32(hash[63:32])};

endmodule
